// ----- rtl/core/pure_pursuit_steering_assert.svh -----
`ifndef PURE_PURSUIT_STEERING_ASSERT_SVH
`define PURE_PURSUIT_STEERING_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pure pursuit check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pure pursuit check failed");

`endif

// ----- rtl/core/pps_pkg.sv -----
package pps_pkg;

  localparam int DEF_MAX_WAYPOINTS = 256;
  localparam int DEF_BACKTRACK     = 5;
  localparam int DEF_CORDIC_STEPS  = 16;
  localparam int TABLE_LEN         = 24;

  localparam logic [29:0] GAIN_Q30    = 30'd652032874;
  localparam logic [16:0] STEER_LIMIT = 17'd23040;
  localparam logic [17:0] DEG_SCALE   = 18'd92160;

  localparam logic [2:0] CFG_WAYPOINT_COUNT  = 3'd0;
  localparam logic [2:0] CFG_LOOKAHEAD_RATIO = 3'd1;
  localparam logic [2:0] CFG_MIN_LOOKAHEAD   = 3'd2;
  localparam logic [2:0] CFG_MAX_LOOKAHEAD   = 3'd3;
  localparam logic [2:0] CFG_AXLE_SPAN       = 3'd4;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_VEHICLE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [7:0]         waypoint_index;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [15:0] speed;
    logic [15:0]        heading;
  } in_item_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [15:0] steer_deg;
    logic signed [15:0] target_speed;
    logic [7:0]         target_index;
  } out_item_t;

  // chosen waypoint relative to the vehicle
  typedef struct packed {
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic [49:0]        d2;
    logic signed [15:0] speed;
  } scan_res_t;

  typedef struct packed {
    logic load;
    logic rotate;
  } cordic_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LA, S_LA2, S_LA3, S_LA4, S_SCAN, S_ROT, S_OFF1, S_OFF2, S_OFF3,
    S_NUM, S_NUM2, S_NORM, S_VEC, S_DEG, S_DEG2
  } state_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'h20000000;
      5'd1:  v = 30'h12E4051D;
      5'd2:  v = 30'h09FB385B;
      5'd3:  v = 30'h051111D4;
      5'd4:  v = 30'h028B0D43;
      5'd5:  v = 30'h0145D7E1;
      5'd6:  v = 30'h00A2F61E;
      5'd7:  v = 30'h00517C55;
      5'd8:  v = 30'h0028BE53;
      5'd9:  v = 30'h00145F2E;
      5'd10: v = 30'h000A2F98;
      5'd11: v = 30'h000517CC;
      5'd12: v = 30'h00028BE6;
      5'd13: v = 30'h000145F3;
      5'd14: v = 30'h0000A2F9;
      5'd15: v = 30'h0000517C;
      5'd16: v = 30'h000028BE;
      5'd17: v = 30'h0000145F;
      5'd18: v = 30'h00000A2F;
      5'd19: v = 30'h00000517;
      5'd20: v = 30'h0000028B;
      5'd21: v = 30'h00000145;
      5'd22: v = 30'h000000A2;
      5'd23: v = 30'h00000051;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/pps_cordic.sv -----
module pps_cordic #(
  parameter int CORDIC_STEPS = pps_pkg::DEF_CORDIC_STEPS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pps_pkg::cordic_ctl_t ctl,
  input  logic signed [42:0]  x_in,
  input  logic signed [42:0]  y_in,
  input  logic signed [34:0]  z_in,
  output logic signed [42:0]  x_out,
  output logic signed [42:0]  y_out,
  output logic signed [34:0]  z_out,
  output logic                done
);
  import pps_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
  localparam logic [4:0] LAST = 5'(NSTEP - 1);

  logic signed [42:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [34:0] z_r, z_nxt;
  logic [4:0]         i_r;
  logic               run_r, rot_r, done_r;
  logic               pos;
  logic signed [34:0] ang;

  // pos: rotate counterclockwise this step
  always_comb begin
    ang   = $signed({5'b0, atan_turn(i_r)});
    pos   = rot_r ? !z_r[34] : y_r[42];
    x_nxt = pos ? x_r - (y_r >>> i_r) : x_r + (y_r >>> i_r);
    y_nxt = pos ? y_r + (x_r >>> i_r) : y_r - (x_r >>> i_r);
    z_nxt = pos ? z_r - ang : z_r + ang;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
      rot_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.load) begin
        run_r <= 1'b1;
        i_r   <= '0;
        rot_r <= ctl.rotate;
      end else if (run_r) begin
        i_r <= i_r + 5'd1;
        if (i_r == LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_r <= x_in;
      y_r <= y_in;
      z_r <= z_in;
    end else if (run_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;
  assign done  = done_r;

endmodule

// ----- rtl/core/pps_path_scan.sv -----
module pps_path_scan #(
  parameter int MAX_WAYPOINTS = pps_pkg::DEF_MAX_WAYPOINTS,
  localparam int AW = $clog2(MAX_WAYPOINTS),
  localparam int CW = AW + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic signed [23:0]  wr_x,
  input  logic signed [23:0]  wr_y,
  input  logic signed [15:0]  wr_speed,
  input  logic                go,
  input  logic [AW-1:0]       start_idx,
  input  logic [CW-1:0]       count,
  input  logic signed [23:0]  px,
  input  logic signed [23:0]  py,
  input  logic [31:0]         ld2,
  output logic                done,
  output logic [AW-1:0]       pick_idx,
  output pps_pkg::scan_res_t  pick
);
  import pps_pkg::*;

  logic [63:0] mem [MAX_WAYPOINTS];
  logic [63:0] rd_r;

  logic          run_r, done_r;
  logic [CW-1:0] addr_r, n_r;
  logic          issue;

  logic          s1_v_r, s2_v_r, s3_v_r;
  logic [AW-1:0] s1_idx_r, s2_idx_r, s3_idx_r, pick_idx_r;
  logic signed [24:0] dx_c, dy_c, s2_dx_r, s2_dy_r, s3_dx_r, s3_dy_r;
  logic [24:0]   ax_c, ay_c, s2_ax_r, s2_ay_r;
  logic signed [15:0] s2_spd_r, s3_spd_r;
  logic [49:0]   sqx_r, sqy_r, d2_c;
  logic          hit, last;
  scan_res_t     pick_r;

  assign issue = run_r && (addr_r < n_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_x, wr_y, wr_speed};
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[addr_r[AW-1:0]];
  end

  always_comb begin
    dx_c = {rd_r[63], rd_r[63:40]} - {px[23], px};
    dy_c = {rd_r[39], rd_r[39:16]} - {py[23], py};
    ax_c = dx_c[24] ? 25'(-dx_c) : 25'(dx_c);
    ay_c = dy_c[24] ? 25'(-dy_c) : 25'(dy_c);
    d2_c = sqx_r + sqy_r;
    hit  = d2_c >= {18'b0, ld2};
    last = {1'b0, s3_idx_r} == (n_r - CW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r  <= 1'b1;
        s1_v_r <= 1'b0;
        s2_v_r <= 1'b0;
        s3_v_r <= 1'b0;
      end else if (s3_v_r && (hit || last)) begin
        // scan ends at the first hit or at the last waypoint
        run_r  <= 1'b0;
        done_r <= 1'b1;
        s1_v_r <= 1'b0;
        s2_v_r <= 1'b0;
        s3_v_r <= 1'b0;
      end else begin
        s1_v_r <= issue;
        s2_v_r <= s1_v_r;
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      addr_r <= {1'b0, start_idx};
      n_r    <= count;
    end else if (issue) begin
      addr_r <= addr_r + CW'(1);
    end
    s1_idx_r <= addr_r[AW-1:0];
    s2_idx_r <= s1_idx_r;
    s2_dx_r  <= dx_c;
    s2_dy_r  <= dy_c;
    s2_ax_r  <= ax_c;
    s2_ay_r  <= ay_c;
    s2_spd_r <= rd_r[15:0];
    s3_idx_r <= s2_idx_r;
    s3_dx_r  <= s2_dx_r;
    s3_dy_r  <= s2_dy_r;
    s3_spd_r <= s2_spd_r;
    sqx_r    <= s2_ax_r * s2_ax_r;
    sqy_r    <= s2_ay_r * s2_ay_r;
    if (s3_v_r) begin
      pick_idx_r   <= s3_idx_r;
      pick_r.dx    <= s3_dx_r;
      pick_r.dy    <= s3_dy_r;
      pick_r.d2    <= d2_c;
      pick_r.speed <= s3_spd_r;
    end
  end

  assign done     = done_r;
  assign pick_idx = pick_idx_r;
  assign pick     = pick_r;

endmodule

// ----- rtl/core/pure_pursuit_steering.sv -----
// load item: no result, busy stays low
// vehicle item: from accept to the result strobe it runs the scan pipeline over k waypoints
// (1 to 256), two CORDIC runs and s normalizing shifts (0 to 39)
// zero offset skips normalize and vectoring, zero distance ends after the scan, empty path
// answers from idle; busy is high meanwhile and the next item is taken in the strobe cycle
// rst_n (synchronous, active low) restores register defaults and target 0; path memory is kept
`include "pure_pursuit_steering_assert.svh"

module pure_pursuit_steering #(
  parameter int MAX_WAYPOINTS = pps_pkg::DEF_MAX_WAYPOINTS,
  parameter int BACKTRACK     = pps_pkg::DEF_BACKTRACK,
  parameter int CORDIC_STEPS  = pps_pkg::DEF_CORDIC_STEPS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pps_pkg::in_item_t  in_item,
  output logic               out_valid,
  output pps_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import pps_pkg::*;

  localparam int AW = $clog2(MAX_WAYPOINTS);
  localparam int CW = AW + 1;
  localparam int WW = (CW > 9) ? CW : 9;

  state_t state_r, state_nxt;

  logic [8:0]  count_r;
  logic [11:0] ratio_r, wb_r;
  logic [15:0] min_r, max_r;
  logic [AW-1:0] cur_r;

  logic signed [23:0] px_r, py_r;
  logic signed [15:0] spd_r;
  logic [15:0] hd_r;
  logic [15:0] ld_r;
  logic [31:0] ld2_r;
  logic signed [61:0] mul_p_r, acc_r;
  logic signed [34:0] mul_a, ang_r;
  logic signed [26:0] mul_b, off_r;
  logic [49:0] ux_r, uy_r, m_c;
  logic        num_neg_r;
  logic        out_valid_r;
  out_item_t   res_r;

  logic accept, veh_accept;
  logic [WW-1:0] n_w, t_w, start_w, slot_w;
  logic [16:0] mag17;
  logic [18:0] ld_raw;
  logic [15:0] ld_c;
  logic signed [33:0] s_c, c_c;
  logic signed [61:0] off_sum;
  logic signed [39:0] num_c;
  logic [40:0] num_mag;
  logic [34:0] ang_mag;
  logic [61:0] deg_sum;
  logic [16:0] deg_mag;

  logic        scan_go, scan_done;
  logic [AW-1:0] pick_idx;
  scan_res_t   pick;
  cordic_ctl_t cctl;
  logic signed [42:0] cx_in, cy_in, cx, cy;
  logic signed [34:0] cz_in, cz;
  logic        c_done;

  assign accept     = start && !busy;
  assign veh_accept = accept && (in_item.kind == KIND_VEHICLE);
  assign busy       = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;

  always_comb begin
    n_w     = (WW'(count_r) < WW'(MAX_WAYPOINTS)) ? WW'(count_r) : WW'(MAX_WAYPOINTS);
    t_w     = (WW'(cur_r) >= n_w) ? n_w - WW'(1) : WW'(cur_r);
    start_w = (t_w > WW'(BACKTRACK)) ? t_w - WW'(BACKTRACK) : '0;
    slot_w  = WW'(in_item.waypoint_index);
    mag17   = spd_r[15] ? 17'(-{spd_r[15], spd_r}) : 17'({spd_r[15], spd_r});
    ld_raw  = mul_p_r[26:8];
    ld_c    = (ld_raw > 19'd65535) ? 16'hFFFF : ld_raw[15:0];
    if (ld_c < min_r) ld_c = min_r;
    if (ld_c > max_r) ld_c = max_r;
    case (hd_r[15:14])
      2'd0: begin c_c = cx[33:0];  s_c = cy[33:0];  end
      2'd1: begin c_c = -cy[33:0]; s_c = cx[33:0];  end
      2'd2: begin c_c = -cx[33:0]; s_c = -cy[33:0]; end
      default: begin c_c = cy[33:0]; s_c = -cx[33:0]; end
    endcase
    off_sum = acc_r + mul_p_r + 62'sd536870912;
    num_c   = mul_p_r[39:0];
    num_mag = num_c[39] ? 41'(-{num_c[39], num_c}) : 41'({num_c[39], num_c});
    m_c     = (ux_r > uy_r) ? ux_r : uy_r;
    ang_mag = ang_r[34] ? 35'(-ang_r) : 35'(ang_r);
    deg_sum = mul_p_r + 62'sd2147483648;
    deg_mag = (deg_sum[48:32] > STEER_LIMIT) ? STEER_LIMIT : deg_sum[48:32];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_LA:   begin mul_a = 35'(mag17);          mul_b = $signed({15'b0, ratio_r}); end
      S_LA3:  begin mul_a = $signed({19'b0, ld_r}); mul_b = $signed({11'b0, ld_r}); end
      S_OFF1: begin mul_a = 35'(s_c);            mul_b = 27'(-pick.dx); end
      S_OFF2: begin mul_a = 35'(c_c);            mul_b = 27'(pick.dy); end
      S_NUM:  begin mul_a = $signed({22'b0, wb_r, 1'b0}); mul_b = off_r; end
      S_DEG:  begin mul_a = $signed(ang_mag);   mul_b = $signed({9'b0, DEG_SCALE}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  always_comb begin
    state_nxt = state_r;
    scan_go   = 1'b0;
    cctl      = '0;
    cx_in     = '0;
    cy_in     = '0;
    cz_in     = '0;
    case (state_r)
      S_IDLE: begin
        // an empty path answers straight from idle
        if (veh_accept && n_w != '0) state_nxt = S_LA;
      end
      S_LA:  state_nxt = S_LA2;
      S_LA2: state_nxt = S_LA3;
      S_LA3: state_nxt = S_LA4;
      S_LA4: begin
        scan_go   = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_done) begin
          if (pick.d2 == '0) begin
            state_nxt = S_IDLE;
          end else begin
            cctl.load   = 1'b1;
            cctl.rotate = 1'b1;
            cx_in       = 43'(GAIN_Q30);
            cz_in       = $signed({3'b0, hd_r[13:0], 18'b0});
            state_nxt   = S_ROT;
          end
        end
      end
      S_ROT: begin
        if (c_done) state_nxt = S_OFF1;
      end
      S_OFF1: state_nxt = S_OFF2;
      S_OFF2: state_nxt = S_OFF3;
      S_OFF3: state_nxt = S_NUM;
      S_NUM:  state_nxt = S_NUM2;
      S_NUM2: state_nxt = (num_mag == '0) ? S_DEG : S_NORM;
      S_NORM: begin
        if (m_c[49:40] == '0 && m_c[39]) begin
          cctl.load = 1'b1;
          cx_in     = $signed({3'b0, ux_r[39:0]});
          cy_in     = $signed({3'b0, uy_r[39:0]});
          state_nxt = S_VEC;
        end
      end
      S_VEC: begin
        if (c_done) state_nxt = S_DEG;
      end
      S_DEG:  state_nxt = S_DEG2;
      S_DEG2: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration and target state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 9'd0;
      ratio_r <= 12'd256;
      min_r   <= 16'd512;
      max_r   <= 16'd2560;
      wb_r    <= 12'd400;
      cur_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WAYPOINT_COUNT:  count_r <= cfg_data[8:0];
          CFG_LOOKAHEAD_RATIO: ratio_r <= cfg_data[11:0];
          CFG_MIN_LOOKAHEAD:   min_r   <= cfg_data;
          CFG_MAX_LOOKAHEAD:   max_r   <= cfg_data;
          CFG_AXLE_SPAN:       wb_r    <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (state_r == S_SCAN && scan_done) cur_r <= pick_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (veh_accept && n_w == '0)
                  || (state_r == S_SCAN && scan_done && pick.d2 == '0)
                  || (state_r == S_DEG2);
    end
  end

  always_ff @(posedge clk) begin
    if (veh_accept) begin
      px_r  <= in_item.point_x;
      py_r  <= in_item.point_y;
      spd_r <= in_item.speed;
      hd_r  <= in_item.heading;
      res_r <= '0;
    end
    case (state_r)
      S_LA2:  ld_r  <= ld_c;
      S_LA4:  ld2_r <= mul_p_r[31:0];
      S_SCAN: res_r <= '0;
      S_OFF2: acc_r <= mul_p_r;
      S_OFF3: off_r <= off_sum[56:30];
      S_NUM2: begin
        num_neg_r <= num_c[39];
        ux_r      <= pick.d2;
        uy_r      <= 50'(num_mag);
        ang_r     <= '0;
      end
      S_NORM: begin
        if (m_c[49:40] != '0) begin
          ux_r <= ux_r >> 1;
          uy_r <= uy_r >> 1;
        end else if (!m_c[39]) begin
          ux_r <= ux_r << 1;
          uy_r <= uy_r << 1;
        end
      end
      S_VEC: begin
        if (c_done) ang_r <= cz;
      end
      S_DEG2: begin
        res_r.valid_res    <= 1'b1;
        res_r.steer_deg    <= (ang_r[34] ^ num_neg_r) ? 16'(-deg_mag) : 16'(deg_mag);
        res_r.target_speed <= pick.speed;
        res_r.target_index <= 8'(cur_r);
      end
      default: ;
    endcase
  end

  pps_path_scan #(
    .MAX_WAYPOINTS(MAX_WAYPOINTS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (accept && in_item.kind == KIND_LOAD && slot_w < WW'(MAX_WAYPOINTS)),
    .wr_addr   (slot_w[AW-1:0]),
    .wr_x      (in_item.point_x),
    .wr_y      (in_item.point_y),
    .wr_speed  (in_item.speed),
    .go        (scan_go),
    .start_idx (start_w[AW-1:0]),
    .count     (n_w[CW-1:0]),
    .px        (px_r),
    .py        (py_r),
    .ld2       (ld2_r),
    .done      (scan_done),
    .pick_idx  (pick_idx),
    .pick      (pick)
  );

  pps_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cctl),
    .x_in  (cx_in),
    .y_in  (cy_in),
    .z_in  (cz_in),
    .x_out (cx),
    .y_out (cy),
    .z_out (cz),
    .done  (c_done)
  );

  assign out_valid = out_valid_r;
  assign out_item  = res_r;

  `PPS_ASSERT_NOW(a_strobe_idle, out_valid_r, state_r == S_IDLE)
  `PPS_ASSERT_NEXT(a_vehicle_busy, veh_accept && n_w != '0, busy)
  `PPS_ASSERT_NOW(a_invalid_zero, out_valid_r && !res_r.valid_res, res_r == '0)
  `PPS_ASSERT_NOW(a_scan_owner, scan_done, state_r == S_SCAN)

endmodule
